[rtl/core/crcdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 48;

    localparam int HDR_LEN     = 7;
    localparam int CRC_LEN     = 2;
    localparam int LEN_W       = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Header byte offsets within a frame body
    localparam int HDR_VERSION = 0;
    localparam int HDR_KIND    = 1;
    localparam int HDR_SEQ_LO  = 2;
    localparam int HDR_SEQ_HI  = 3;
    localparam int HDR_COMMAND = 4;
    localparam int HDR_LEN_LO  = 5;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Result status codes
    localparam logic [1:0] STS_GOOD = 2'd0;
    localparam logic [1:0] STS_CRC  = 2'd1;
    localparam logic [1:0] STS_LEN  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT   = 2'd3;

    localparam logic [7:0]  SOF_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SOF_SECOND_RST = 8'h55;
    localparam logic [31:0] TIMEOUT_RST    = 32'd100;
    localparam logic [15:0] CRC_INIT_RST   = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_RD  = 2'd1,
        ST_PAY = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0]  sof_first;
        logic [7:0]  sof_second;
        logic [31:0] timeout_ms;
        logic [15:0] crc_init;
    } t_cfg;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic pay_load;  // load next payload result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic emit;      // accepted word produces a result
        logic pay_run;   // good frame with a non-empty payload
        logic idx_last;  // current payload index is the final one
    } t_dp_sts;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = ((c & CRC_TOP) != 16'h0000) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/crcdf_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcdf_cfg
// Configuration register bank: marker bytes, idle timeout and CRC seed.
// ----------------------------------------------------------------------------
module crcdf_cfg
    import crcdf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sof_first  <= SOF_FIRST_RST;
            r_cfg.sof_second <= SOF_SECOND_RST;
            r_cfg.timeout_ms <= TIMEOUT_RST;
            r_cfg.crc_init   <= CRC_INIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOF_FIRST:  r_cfg.sof_first  <= i_cfg_data[7:0];
                CFG_SOF_SECOND: r_cfg.sof_second <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.timeout_ms <= i_cfg_data;
                CFG_CRC_INIT:   r_cfg.crc_init   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/crcdf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcdf_ctrl
// Controller: input handshake, output valid and the payload emission sequence.
// ----------------------------------------------------------------------------
module crcdf_ctrl
    import crcdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_s_tvalid && out_free && i_sts.pay_run) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_PAY;
            end
            ST_PAY: begin
                if (out_free) begin
                    n_state = i_sts.idx_last ? ST_RUN : ST_RD;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.pay_load = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_s_tready   = out_free;
                o_cmd.accept = i_s_tvalid && out_free;
            end
            ST_PAY: begin
                o_cmd.pay_load = out_free;
            end
            default: begin
            end
        endcase
        // hold the word until taken, refill on a new result
        if ((o_cmd.accept && i_sts.emit) || o_cmd.pay_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

[rtl/core/crcdf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crcdf_dp
// Datapath: marker hunt, header capture, CRC, payload store, counters and the
// output result register.
// ----------------------------------------------------------------------------
module crcdf_dp
    import crcdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_req_type,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic [31:0]            i_now_ms,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic [OUT_TUSER_W-1:0]      o_tuser,
    output logic                        o_tlast
);

    localparam int STORE_LEN = HDR_LEN + int'(MAX_PAYLOAD_BYTES) + CRC_LEN;
    localparam int CNT_W     = $clog2(STORE_LEN + 1);
    localparam int IDX_W     = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int IDXP_W    = LEN_W + 1;

    // Hunt and frame state
    t_phase            r_phase;
    t_phase            n_phase;
    logic [CNT_W-1:0]  r_rcv;
    logic [CNT_W-1:0]  n_rcv;
    logic [CNT_W-1:0]  r_exp;
    logic [CNT_W-1:0]  n_exp;
    logic [15:0]       r_crc;
    logic [15:0]       n_crc;
    logic [31:0]       r_last_time;
    logic [31:0]       n_last_time;
    logic [15:0]       r_crc_cnt;
    logic [15:0]       n_crc_cnt;
    logic [15:0]       r_len_cnt;
    logic [15:0]       n_len_cnt;

    // Header fields and previous byte
    logic [7:0]        r_version;
    logic [7:0]        r_kind;
    logic [15:0]       r_seq;
    logic [7:0]        r_command;
    logic [7:0]        r_len_lo;
    logic [7:0]        r_prev;

    // Payload store
    logic [7:0]        r_mem [MAX_PAYLOAD_BYTES];
    logic [7:0]        r_rd_data;
    logic [IDX_W-1:0]  r_idx;

    // Result register
    logic [1:0]        r_res_status;
    logic [LEN_W-1:0]  r_res_len;
    logic [7:0]        r_res_byte;
    logic              r_res_bvalid;
    logic              r_res_last;

    logic [CNT_W-1:0]  rcv_inc;
    logic [CNT_W-1:0]  exp_body;
    logic [15:0]       len16;
    logic [15:0]       rx_crc;
    logic [31:0]       gap;
    logic              body_wr;
    logic              mem_wr;
    logic              emit_len;
    logic              emit_crc;
    logic              emit_good;
    logic              len_zero;

    assign rcv_inc  = r_rcv + CNT_W'(1);
    assign exp_body = r_exp - CNT_W'(CRC_LEN);
    assign len16    = {i_data_byte, r_len_lo};
    assign rx_crc   = {i_data_byte, r_prev};
    assign gap      = i_now_ms - r_last_time;
    assign len_zero = (r_exp == CNT_W'(HDR_LEN + CRC_LEN));

    always_comb begin
        n_phase     = r_phase;
        n_rcv       = r_rcv;
        n_exp       = r_exp;
        n_crc       = r_crc;
        n_last_time = r_last_time;
        n_crc_cnt   = r_crc_cnt;
        n_len_cnt   = r_len_cnt;
        body_wr     = 1'b0;
        mem_wr      = 1'b0;
        emit_len    = 1'b0;
        emit_crc    = 1'b0;
        emit_good   = 1'b0;
        if (i_cmd.accept) begin
            if (i_req_type) begin
                // abandon an open hunt after an idle gap
                if (r_phase != PH_FIRST && gap > i_cfg.timeout_ms) begin
                    n_phase = PH_FIRST;
                    n_rcv   = '0;
                    n_exp   = '0;
                end
            end else begin
                n_last_time = i_now_ms;
                case (r_phase)
                    PH_SECOND: begin
                        if (i_data_byte == i_cfg.sof_second) begin
                            n_phase = PH_BODY;
                            n_rcv   = '0;
                            n_exp   = '0;
                            n_crc   = i_cfg.crc_init;
                        end else if (i_data_byte == i_cfg.sof_first) begin
                            n_phase = PH_SECOND;
                        end else begin
                            n_phase = PH_FIRST;
                        end
                    end
                    PH_BODY: begin
                        if (r_rcv >= CNT_W'(STORE_LEN)) begin
                            n_phase = PH_FIRST;
                            n_rcv   = '0;
                            n_exp   = '0;
                        end else begin
                            body_wr = 1'b1;
                            n_rcv   = rcv_inc;
                            if (r_exp == '0 || r_rcv < exp_body) begin
                                n_crc = crc_add(r_crc, i_data_byte);
                            end
                            mem_wr = (r_exp != '0) && (r_rcv >= CNT_W'(HDR_LEN))
                                     && (r_rcv < exp_body);
                            if (rcv_inc == CNT_W'(HDR_LEN)) begin
                                if (len16 > 16'(MAX_PAYLOAD_BYTES)) begin
                                    emit_len = 1'b1;
                                    if (r_len_cnt != 16'hFFFF) begin
                                        n_len_cnt = r_len_cnt + 16'd1;
                                    end
                                    n_phase = PH_FIRST;
                                    n_rcv   = '0;
                                    n_exp   = '0;
                                end else begin
                                    n_exp = CNT_W'(HDR_LEN + CRC_LEN)
                                            + CNT_W'(len16[LEN_W-1:0]);
                                end
                            end else if (r_exp != '0 && rcv_inc >= r_exp) begin
                                if (rx_crc != r_crc) begin
                                    emit_crc = 1'b1;
                                    if (r_crc_cnt != 16'hFFFF) begin
                                        n_crc_cnt = r_crc_cnt + 16'd1;
                                    end
                                end else begin
                                    emit_good = 1'b1;
                                end
                                n_phase = PH_FIRST;
                                n_rcv   = '0;
                                n_exp   = '0;
                            end
                        end
                    end
                    default: begin
                        n_phase = (i_data_byte == i_cfg.sof_first) ? PH_SECOND : PH_FIRST;
                    end
                endcase
            end
        end
    end

    assign o_sts.emit     = emit_len || emit_crc || emit_good;
    assign o_sts.pay_run  = emit_good && !len_zero;
    assign o_sts.idx_last = (IDXP_W'(r_idx) + IDXP_W'(1)) == {1'b0, r_res_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_rcv       <= '0;
            r_exp       <= '0;
            r_crc       <= CRC_INIT_RST;
            r_last_time <= '0;
            r_crc_cnt   <= '0;
            r_len_cnt   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_rcv       <= n_rcv;
            r_exp       <= n_exp;
            r_crc       <= n_crc;
            r_last_time <= n_last_time;
            r_crc_cnt   <= n_crc_cnt;
            r_len_cnt   <= n_len_cnt;
        end
    end

    // Header capture; these fields stay put while a result is on the output
    always_ff @(posedge i_clk) begin
        if (body_wr) begin
            r_prev <= i_data_byte;
            case (r_rcv)
                CNT_W'(HDR_VERSION): r_version     <= i_data_byte;
                CNT_W'(HDR_KIND):    r_kind        <= i_data_byte;
                CNT_W'(HDR_SEQ_LO):  r_seq[7:0]    <= i_data_byte;
                CNT_W'(HDR_SEQ_HI):  r_seq[15:8]   <= i_data_byte;
                CNT_W'(HDR_COMMAND): r_command     <= i_data_byte;
                CNT_W'(HDR_LEN_LO):  r_len_lo      <= i_data_byte;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[IDX_W'(r_rcv - CNT_W'(HDR_LEN))] <= i_data_byte;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (emit_good) begin
            r_idx <= '0;
        end else if (i_cmd.pay_load) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sts.emit) begin
            r_res_byte   <= 8'h00;
            r_res_bvalid <= 1'b0;
            if (emit_len) begin
                r_res_status <= STS_LEN;
                r_res_len    <= '0;
                r_res_last   <= 1'b1;
            end else begin
                r_res_status <= emit_crc ? STS_CRC : STS_GOOD;
                r_res_len    <= LEN_W'(r_exp - CNT_W'(HDR_LEN + CRC_LEN));
                r_res_last   <= emit_crc || len_zero;
            end
        end else if (i_cmd.pay_load) begin
            r_res_status <= STS_GOOD;
            r_res_byte   <= r_rd_data;
            r_res_bvalid <= 1'b1;
            r_res_last   <= o_sts.idx_last;
        end
    end

    assign o_tdata = {2'b00, r_len_cnt, r_crc_cnt, r_res_byte, r_res_len,
                      r_command, r_seq, r_kind, r_version};
    assign o_tuser = {r_res_bvalid, r_res_status};
    assign o_tlast = r_res_last;

endmodule
`default_nettype wire

[rtl/core/crc_frame_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc_frame_deframer
// Start-marker hunt, header/length parse and CRC-16 check of a byte stream.
// ----------------------------------------------------------------------------
// Each input word is absorbed in the cycle it is accepted; a result is visible the cycle after
// the accepting edge. A good frame emits its header word, then one word per payload byte,
// each from a payload memory read (ST_RD) followed by an output load (ST_PAY); input is
// stalled for that run and whenever the output register holds a word that is not being taken.
// Reset (synchronous, active low) restores the register defaults, the hunt
// state and the counters; the payload memory needs no clearing pass.
module crc_frame_deframer
    import crcdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tdata: data_byte[7:0], now_ms[39:8]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: req_type[0]
    input  wire logic [IN_TUSER_W-1:0]  i_s_tuser,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: version[7:0], kind[15:8], sequence_res[31:16], command[39:32],
    //        payload_length[45:40], payload_byte[53:46], crc_error_count[69:54],
    //        length_error_count[85:70], zero fill[87:86]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: status[1:0], byte_valid[2]
    output logic [OUT_TUSER_W-1:0]      o_m_tuser,
    output logic                        o_m_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    crcdf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crcdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    crcdf_dp #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_s_tuser[0]),
        .i_data_byte (i_s_tdata[7:0]),
        .i_now_ms    (i_s_tdata[39:8]),
        .o_tdata     (o_m_tdata),
        .o_tuser     (o_m_tuser),
        .o_tlast     (o_m_tlast)
    );

    // A word waiting on the output blocks new input
    a_no_accept_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output word is stalled");

    // Input acceptance and payload emission never overlap
    a_accept_excl_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && cmd.pay_load))
        else $error("input accepted during payload run");

    // Error results always close their run
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] != STS_GOOD) |-> o_m_tlast)
        else $error("error result not marked last");

    // Saturating CRC error counter never decreases
    a_crc_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_m_tdata[69:54] >= $past(o_m_tdata[69:54])))
        else $error("CRC error counter decreased");

endmodule
`default_nettype wire
